@@ hdl/hbmk_pkg.sv @@
package hbmk_pkg;

  localparam int unsigned DotTicksW = 16;
  localparam int unsigned UnitsW = 3;
  localparam int unsigned DurW = 18;
  localparam int unsigned ElemW = 3;
  localparam int unsigned MaxElems = 5;

  localparam logic [DotTicksW-1:0] DOT_TICKS_RESET = 16'd100;

  localparam logic [UnitsW-1:0] DASH_UNITS = 3'd3;
  localparam logic [UnitsW-1:0] DOT_UNITS = 3'd1;
  localparam logic [UnitsW-1:0] GAP_UNITS = 3'd1;
  localparam logic [UnitsW-1:0] DIGIT_END_UNITS = 3'd4;

  typedef enum logic [1:0] {
    SEG_DOT,
    SEG_DASH,
    SEG_GAP,
    SEG_END
  } seg_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      next_elem;
    logic      next_digit;
    logic      emit;
    seg_kind_t kind;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_dash;
    logic elem_last;
    logic digit_low;
  } dp_status_t;

  // Number of elements in the Morse pattern of a hex digit.
  function automatic logic [ElemW-1:0] pattern_len(input logic [3:0] nibble);
    logic [ElemW-1:0] len;
    case (nibble)
      4'hA: len = 3'd2;
      4'hB: len = 3'd4;
      4'hC: len = 3'd4;
      4'hD: len = 3'd3;
      4'hE: len = 3'd1;
      4'hF: len = 3'd4;
      default: len = 3'd5;
    endcase
    return len;
  endfunction

  // Bit i set means element i is a dash.
  function automatic logic [MaxElems-1:0] pattern_dash(input logic [3:0] nibble);
    logic [MaxElems-1:0] dash;
    case (nibble)
      4'h0: dash = 5'h1F;
      4'h1: dash = 5'h1E;
      4'h2: dash = 5'h1C;
      4'h3: dash = 5'h18;
      4'h4: dash = 5'h10;
      4'h5: dash = 5'h00;
      4'h6: dash = 5'h01;
      4'h7: dash = 5'h03;
      4'h8: dash = 5'h07;
      4'h9: dash = 5'h0F;
      4'hA: dash = 5'h02;
      4'hB: dash = 5'h01;
      4'hC: dash = 5'h05;
      4'hD: dash = 5'h01;
      4'hE: dash = 5'h00;
      default: dash = 5'h04;
    endcase
    return dash;
  endfunction

  function automatic logic [UnitsW-1:0] seg_units(input seg_kind_t kind);
    logic [UnitsW-1:0] u;
    case (kind)
      SEG_DOT: u = DOT_UNITS;
      SEG_DASH: u = DASH_UNITS;
      SEG_GAP: u = GAP_UNITS;
      SEG_END: u = DIGIT_END_UNITS;
      default: u = GAP_UNITS;
    endcase
    return u;
  endfunction

endpackage

@@ hdl/hbmk_ctrl.sv @@
module hbmk_ctrl
  import hbmk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_SPACE,
    S_GAP,
    S_END
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '{load: 1'b0, next_elem: 1'b0, next_digit: 1'b0, emit: 1'b0, kind: SEG_GAP};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        cmd.emit = 1'b1;
        cmd.kind = status.is_dash ? SEG_DASH : SEG_DOT;
        state_nxt = S_SPACE;
      end
      S_SPACE: begin
        cmd.emit = 1'b1;
        cmd.kind = SEG_GAP;
        state_nxt = status.elem_last ? S_END : S_GAP;
      end
      S_GAP: begin
        cmd.emit = 1'b1;
        cmd.kind = SEG_GAP;
        cmd.next_elem = 1'b1;
        state_nxt = S_MARK;
      end
      S_END: begin
        cmd.emit = 1'b1;
        cmd.kind = SEG_END;
        cmd.next_digit = 1'b1;
        state_nxt = status.digit_low ? S_IDLE : S_MARK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/hbmk_dp.sv @@
module hbmk_dp
  import hbmk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  input  logic [7:0]           byte_in,
  input  logic                 dot_we,
  input  logic [DotTicksW-1:0] dot_wdata,
  output dp_status_t           status,
  output logic                 out_valid,
  output logic                 out_led_on,
  output logic [UnitsW-1:0]    out_units,
  output logic [DurW-1:0]      out_duration_ticks,
  output logic                 out_last
);

  logic [7:0]           byte_r;
  logic                 digit_low_r;
  logic [ElemW-1:0]     elem_r;
  logic [DotTicksW-1:0] dot_ticks_r;
  logic                 valid_r;
  logic                 led_r;
  logic [UnitsW-1:0]    units_r;
  logic [DurW-1:0]      dur_r;
  logic                 last_r;

  logic [3:0]                  nibble;
  logic [MaxElems-1:0]         dash_bits;
  logic [ElemW-1:0]            len;
  logic [UnitsW-1:0]           units_nxt;
  logic [UnitsW+DotTicksW-1:0] prod;

  assign nibble    = digit_low_r ? byte_r[3:0] : byte_r[7:4];
  assign dash_bits = pattern_dash(nibble);
  assign len       = pattern_len(nibble);

  assign status.is_dash   = dash_bits[elem_r];
  assign status.elem_last = (elem_r == len - 3'd1);
  assign status.digit_low = digit_low_r;

  assign units_nxt = seg_units(cmd.kind);
  assign prod      = units_nxt * dot_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_ticks_r <= DOT_TICKS_RESET;
      valid_r     <= 1'b0;
    end else begin
      if (dot_we) begin
        dot_ticks_r <= dot_wdata;
      end
      valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r      <= byte_in;
      digit_low_r <= 1'b0;
      elem_r      <= '0;
    end else if (cmd.next_digit) begin
      digit_low_r <= 1'b1;
      elem_r      <= '0;
    end else if (cmd.next_elem) begin
      elem_r <= elem_r + 3'd1;
    end
    if (cmd.emit) begin
      led_r   <= (cmd.kind == SEG_DOT) || (cmd.kind == SEG_DASH);
      units_r <= units_nxt;
      dur_r   <= prod[DurW-1:0];
      last_r  <= (cmd.kind == SEG_END) && digit_low_r;
    end
  end

  assign out_valid          = valid_r;
  assign out_led_on         = led_r;
  assign out_units          = units_r;
  assign out_duration_ticks = dur_r;
  assign out_last           = last_r;

endmodule

@@ hdl/hex_byte_morse_keyer.sv @@
// Sends one byte as Morse code, high hex digit first, as a stream of LED
// segments. Pulse start while busy is low to hand over a word; busy then
// stays high until the last segment has been issued. Each segment appears on
// the out_ ports for exactly one cycle with out_valid high, and the receiver
// cannot stall it, so it must take every segment as it comes. A byte gives 6
// to 30 segments, one per cycle. Once start is taken, the controller state
// machine moves to its mark state, which issues the first segment, and the
// datapath then registers each segment. The dot length register
// is written through the cfg_ channel, which is ready only while busy is low
// and no segment is on the out_ ports.
module hex_byte_morse_keyer
  import hbmk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [7:0]           in_byte_in,
  output logic                 out_valid,
  output logic                 out_led_on,
  output logic [UnitsW-1:0]    out_units,
  output logic [DurW-1:0]      out_duration_ticks,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [DotTicksW-1:0] cfg_dot_ticks
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The dot length is taken whenever the keyer is not sending a word and the
  // final segment of the previous word has left the outputs.
  assign cfg_ready = ~busy & ~out_valid;

  // The controller walks the pattern of each digit: mark, space, and then
  // either an inter-element gap or the closing four-unit gap.
  hbmk_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // The datapath holds the word, the digit and element position, the dot
  // length register and the registered segment outputs.
  hbmk_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .byte_in            (in_byte_in),
    .dot_we             (cfg_valid & cfg_ready),
    .dot_wdata          (cfg_dot_ticks),
    .status             (status),
    .out_valid          (out_valid),
    .out_led_on         (out_led_on),
    .out_units          (out_units),
    .out_duration_ticks (out_duration_ticks),
    .out_last           (out_last)
  );

endmodule

@@ sim/tb_hex_byte_morse_keyer.sv @@
// Testbench for the hex byte Morse keyer.
//
// Bytes are handed to the block over the start/busy command handshake. Each
// accepted word is expanded right away into the segments that it must
// produce: a dash or dot and a gap per element, one more gap between
// elements, and the closing gap after each digit. They wait in a queue.
// Every segment that the block strobes out is then compared with the
// oldest one in the queue. The dot length register is changed only while
// the keyer is idle, and the model follows every accepted cfg_ write.
module tb_hex_byte_morse_keyer;
  timeunit 1ns;
  timeprecision 1ps;

  import hbmk_pkg::*;

  // Cycles without any handshake before the run is declared hung. This is
  // far above the longest sender gap seen at the highest idle rate.
  localparam int unsigned StallLimit = 3000;
  // Cycles to let pass after the last segment, so that a stray extra
  // segment still shows up.
  localparam int unsigned DrainCycles = 40;
  // Random words per phase of the random part.
  localparam int unsigned WordsPerPhase = 60;

  // One segment word as it appears on the out_ ports.
  typedef struct packed {
    logic              led_on;
    logic [UnitsW-1:0] units;
    logic [DurW-1:0]   duration_ticks;
    logic              last;
  } seg_word_t;

  // Expands accepted bytes into Morse segments and checks the block's
  // segments against them in order.
  class morse_segment_board;
    seg_word_t            pending_segments[$];
    logic [DotTicksW-1:0] dot_ticks;
    int unsigned          errors;

    function new();
      dot_ticks = DOT_TICKS_RESET;
      errors = 0;
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endfunction

    // Element strings of the sixteen hex digits, sent left to right.
    function string digit_code(logic [3:0] nibble);
      string code;
      case (nibble)
        4'h0: code = "-----";
        4'h1: code = ".----";
        4'h2: code = "..---";
        4'h3: code = "...--";
        4'h4: code = "....-";
        4'h5: code = ".....";
        4'h6: code = "-....";
        4'h7: code = "--...";
        4'h8: code = "---..";
        4'h9: code = "----.";
        4'hA: code = ".-";
        4'hB: code = "-...";
        4'hC: code = "-.-.";
        4'hD: code = "-..";
        4'hE: code = ".";
        default: code = "..-.";
      endcase
      return code;
    endfunction

    function void add_segment(seg_kind_t kind, logic last);
      seg_word_t         seg;
      logic [UnitsW-1:0] units;
      logic [DurW-1:0]   units_wide;
      logic [DurW-1:0]   dot_wide;
      case (kind)
        SEG_DASH: units = DASH_UNITS;
        SEG_DOT:  units = DOT_UNITS;
        SEG_GAP:  units = GAP_UNITS;
        default:  units = DIGIT_END_UNITS;
      endcase
      units_wide = units;
      dot_wide = dot_ticks;
      seg.led_on = (kind == SEG_DASH) || (kind == SEG_DOT);
      seg.units = units;
      seg.duration_ticks = units_wide * dot_wide;
      seg.last = last;
      pending_segments.push_back(seg);
    endfunction

    function void add_digit(logic [3:0] nibble, logic final_digit);
      string code;
      code = digit_code(nibble);
      for (int i = 0; i < code.len(); i++) begin
        if (i > 0) begin
          add_segment(SEG_GAP, 1'b0);
        end
        add_segment((code[i] == "-") ? SEG_DASH : SEG_DOT, 1'b0);
        add_segment(SEG_GAP, 1'b0);
      end
      add_segment(SEG_END, final_digit);
    endfunction

    // Called for every byte that the block accepts.
    function void note_byte(logic [7:0] value);
      add_digit(value[7:4], 1'b0);
      add_digit(value[3:0], 1'b1);
    endfunction

    // Called for every segment that the block strobes out.
    function void check_segment(seg_word_t got);
      seg_word_t want;
      if (pending_segments.size() == 0) begin
        report("segment with nothing pending, duration_ticks", 0, got.duration_ticks);
        return;
      end
      want = pending_segments.pop_front();
      if (got.led_on !== want.led_on) begin
        report("led_on", want.led_on, got.led_on);
      end
      if (got.units !== want.units) begin
        report("units", want.units, got.units);
      end
      if (got.duration_ticks !== want.duration_ticks) begin
        report("duration_ticks", want.duration_ticks, got.duration_ticks);
      end
      if (got.last !== want.last) begin
        report("last", want.last, got.last);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [7:0]           in_byte_in;
  logic                 out_valid;
  logic                 out_led_on;
  logic [UnitsW-1:0]    out_units;
  logic [DurW-1:0]      out_duration_ticks;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [DotTicksW-1:0] cfg_dot_ticks;

  morse_segment_board board;
  int unsigned        quiet_cycles = 0;

  // The directed words cover every digit in both the high and the low
  // position, the all-zero and all-one bytes, and alternating bit patterns.
  logic [7:0] directed_bytes[$] = '{
    8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB,
    8'hCD, 8'hEF, 8'h10, 8'h32, 8'h54, 8'h76, 8'h98, 8'hBA, 8'hDC, 8'hFE,
    8'h55, 8'hAA
  };

  hex_byte_morse_keyer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_byte_in         (in_byte_in),
    .out_valid          (out_valid),
    .out_led_on         (out_led_on),
    .out_units          (out_units),
    .out_duration_ticks (out_duration_ticks),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_dot_ticks      (cfg_dot_ticks)
  );

  always #4 clk = ~clk;

  // All handshakes are observed at the rising edge. Every signal read here
  // is driven by a nonblocking assignment, so the values seen are the ones
  // that held just before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        board.check_segment('{out_led_on, out_units, out_duration_ticks, out_last});
      end
      if (start && !busy) begin
        board.note_byte(in_byte_in);
      end
      if (cfg_valid && cfg_ready) begin
        board.dot_ticks = cfg_dot_ticks;
      end
    end
  end

  // Hang detection: any word moving on any channel restarts the count.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("tb_hex_byte_morse_keyer NOT OK");
      $finish;
    end
  end

  // Offers one byte. The sender may first hold start low for a random number
  // of cycles; once start is high it stays high until busy is seen low at a
  // rising edge. The caller's next word may keep start high without a gap,
  // so start is never lowered and raised in the same step.
  task automatic send_byte(input logic [7:0] value, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_byte_in <= value;
    do @(posedge clk); while (busy);
  endtask

  // Waits until every pending segment has come out and busy has dropped.
  task automatic wait_for_idle();
    start <= 1'b0;
    do @(posedge clk); while (board.pending_segments.size() != 0 || busy);
  endtask

  // Changes the dot length between bytes. Spare cycles follow the last
  // segment so that the keyer is surely back in its idle state.
  task automatic set_dot_ticks(input logic [DotTicksW-1:0] value);
    wait_for_idle();
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_dot_ticks <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned          idle_pct;
    logic [DotTicksW-1:0] dot_value;

    board = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_byte_in = '0;
    cfg_valid = 1'b0;
    cfg_dot_ticks = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset dot length, sent back to back.
    foreach (directed_bytes[i]) begin
      send_byte(directed_bytes[i], 0);
    end

    // A zero dot length must give zero ticks on every segment.
    set_dot_ticks('0);
    send_byte(8'h0E, 0);
    send_byte(8'hE0, 0);

    // The largest dot length gives the longest durations, 4 units of it.
    set_dot_ticks('1);
    send_byte(8'hBC, 0);

    // Random part: the sender first idles about a quarter of the cycles,
    // then two thirds of them, then not at all. Every phase runs with a dot
    // length of its own, the extremes among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: dot_value = DotTicksW'($urandom_range(65535));
        1: dot_value = '1;
        2: dot_value = DotTicksW'($urandom_range(65535));
        3: dot_value = DotTicksW'(1);
        4: dot_value = '0;
        default: dot_value = DOT_TICKS_RESET;
      endcase
      idle_pct = (phase < 2) ? 27 : (phase < 4) ? 66 : 0;
      set_dot_ticks(dot_value);
      for (int n = 0; n < WordsPerPhase; n++) begin
        send_byte(8'($urandom_range(255)), idle_pct);
      end
    end

    wait_for_idle();
    repeat (DrainCycles) @(posedge clk);

    if (board.errors == 0 && board.pending_segments.size() == 0) begin
      $display("tb_hex_byte_morse_keyer OK");
    end else begin
      $display("tb_hex_byte_morse_keyer NOT OK");
    end
    $finish;
  end

endmodule
